/* rtl/core/gps_pkg.sv */
`default_nettype none
package gps_pkg;

  localparam logic [1:0] MODE_RECT  = 2'd0;
  localparam logic [1:0] MODE_GAUSS = 2'd1;
  localparam logic [1:0] MODE_ZERO  = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;
  localparam logic [1:0] REG_LENGTH = 2'd3;

  localparam int unsigned SPAN_SIGMAS_DEF   = 8;
  localparam int unsigned CENTER_SIGMAS_DEF = 4;
  localparam int unsigned AMP_FRAC_BITS     = 15;

  localparam logic [30:0] Q_ONE       = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [28:0] LOG2E_Q28   = 29'd387270501;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [15:0] AMP_MAX     = 16'd32767;

  localparam int unsigned CAR_STAGES       = 12;
  localparam int unsigned ENV_FIXED_STAGES = 29;

  localparam int unsigned RCP_SHIFT = 38;
  typedef logic [38:0] rcp_t;
  localparam longint unsigned RCP_NUM = 64'd1 << RCP_SHIFT;

  localparam rcp_t COS_RCP [4] = '{
    rcp_t'((RCP_NUM + 64'd55) / 64'd56), rcp_t'((RCP_NUM + 64'd29) / 64'd30),
    rcp_t'((RCP_NUM + 64'd11) / 64'd12), rcp_t'((RCP_NUM + 64'd1) / 64'd2)};
  localparam rcp_t SIN_RCP [4] = '{
    rcp_t'((RCP_NUM + 64'd71) / 64'd72), rcp_t'((RCP_NUM + 64'd41) / 64'd42),
    rcp_t'((RCP_NUM + 64'd19) / 64'd20), rcp_t'((RCP_NUM + 64'd5) / 64'd6)};
  localparam rcp_t EXP_RCP [12] = '{
    rcp_t'((RCP_NUM + 64'd11) / 64'd12), rcp_t'((RCP_NUM + 64'd10) / 64'd11),
    rcp_t'((RCP_NUM + 64'd9) / 64'd10), rcp_t'((RCP_NUM + 64'd8) / 64'd9),
    rcp_t'((RCP_NUM + 64'd7) / 64'd8), rcp_t'((RCP_NUM + 64'd6) / 64'd7),
    rcp_t'((RCP_NUM + 64'd5) / 64'd6), rcp_t'((RCP_NUM + 64'd4) / 64'd5),
    rcp_t'((RCP_NUM + 64'd3) / 64'd4), rcp_t'((RCP_NUM + 64'd2) / 64'd3),
    rcp_t'((RCP_NUM + 64'd1) / 64'd2), rcp_t'(RCP_NUM)};

  // Exact floor division by a small constant through its rounded-up reciprocal.
  function automatic logic [30:0] cdiv(logic [30:0] a, rcp_t m);
    logic [69:0] p;
    p = {39'd0, a} * {31'd0, m};
    return p[68:38];
  endfunction

  // Q30 product of two Q30 values.
  function automatic logic [30:0] mulq(logic [30:0] a, logic [30:0] b);
    logic [61:0] p;
    p = {31'd0, a} * {31'd0, b};
    return p[60:30];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/gps_carrier.sv */
`default_nettype none
module gps_carrier
  import gps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [31:0] sample_time_i,
  input  wire logic [31:0] phase_step_i,
  input  wire logic [31:0] phase_offset_i,
  output logic      [30:0] mag_o,
  output logic             neg_o
);

  typedef struct packed {
    logic        neg;
    logic        cos;
    logic [30:0] x;
    logic [30:0] x2;
    logic [30:0] v;
  } car_st_t;

  logic [31:0] prod_q;
  logic [31:0] phase;
  logic [30:0] r0;
  logic [30:0] r;
  logic [30:0] m;
  car_st_t     st_d [10];
  car_st_t     st_q [10];
  logic [30:0] mag_q;
  logic        neg_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 32'(sample_time_i * phase_step_i);
  end

  always_comb begin
    phase = prod_q + phase_offset_i;
    r0    = {1'b0, phase[29:0]};
    r     = phase[30] ? Q_ONE - r0 : r0;

    st_d[0].neg = phase[31] ^ phase[30];
    st_d[0].cos = (r <= (Q_ONE >> 1));
    st_d[0].x   = '0;
    st_d[0].x2  = '0;
    st_d[0].v   = st_d[0].cos ? r : Q_ONE - r;

    st_d[1]   = st_q[0];
    st_d[1].x = mulq(st_q[0].v, HALF_PI_Q30);

    st_d[2]    = st_q[1];
    st_d[2].x2 = mulq(st_q[1].x, st_q[1].x);

    st_d[3]   = st_q[2];
    st_d[3].v = Q_ONE - cdiv(st_q[2].x2, st_q[2].cos ? COS_RCP[0] : SIN_RCP[0]);

    for (int j = 1; j < 4; j++) begin
      st_d[2*j+2]   = st_q[2*j+1];
      st_d[2*j+2].v = mulq(st_q[2*j+1].x2, st_q[2*j+1].v);
      st_d[2*j+3]   = st_q[2*j+2];
      st_d[2*j+3].v = Q_ONE - cdiv(st_q[2*j+2].v,
                                   st_q[2*j+2].cos ? COS_RCP[j] : SIN_RCP[j]);
    end

    m = st_q[9].cos ? st_q[9].v : mulq(st_q[9].x, st_q[9].v);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 10; i++) begin
      st_q[i] <= st_d[i];
    end
    mag_q <= (m > Q_ONE) ? Q_ONE : m;
    neg_q <= st_q[9].neg;
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule
`default_nettype wire

/* rtl/core/gps_envelope.sv */
`default_nettype none
module gps_envelope
  import gps_pkg::*;
#(
  parameter int unsigned SPAN_SIGMAS   = SPAN_SIGMAS_DEF,
  parameter int unsigned CENTER_SIGMAS = CENTER_SIGMAS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic [31:0] sample_time_i,
  input  wire logic [31:0] pulse_length_i,
  output logic      [30:0] env_o
);

  localparam int unsigned MAXSC = (SPAN_SIGMAS > CENTER_SIGMAS) ? SPAN_SIGMAS : CENTER_SIGMAS;
  localparam int unsigned DDW   = 32 + $clog2(MAXSC + 1);
  localparam int unsigned UW    = DDW - 8;

  typedef struct packed {
    logic [31:0]   rem;
    logic [UW-1:0] quo;
    logic [UW-1:0] low;
  } div_st_t;

  typedef struct packed {
    logic        zero;
    logic [4:0]  n;
    logic [29:0] z;
    logic [30:0] acc;
  } exp_st_t;

  logic [DDW-1:0]    a;
  logic [DDW-1:0]    b;
  logic [DDW-1:0]    d_q;
  logic [UW+31:0]    dividend;
  div_st_t           dv_d [UW];
  div_st_t           dv_q [UW];
  logic [32:0]       trial [UW];
  logic [63:0]       uu;
  logic [63:0]       vv;
  logic [34:0]       v_q;
  logic              zv_q;
  logic [46:0]       pl_q;
  logic [45:0]       ph_q;
  logic              zw_q;
  logic [63:0]       w;
  logic [4:0]        n_q;
  logic [29:0]       f_q;
  logic              zf_q;
  logic [30:0]       z0;
  exp_st_t           ex_d [24];
  exp_st_t           ex_q [24];
  logic [31:0]       shifted;
  logic [30:0]       env_q;

  assign a = DDW'(sample_time_i) * DDW'(SPAN_SIGMAS);
  assign b = DDW'(pulse_length_i) * DDW'(CENTER_SIGMAS);

  always_ff @(posedge clk_i) begin
    d_q <= (a > b) ? a - b : b - a;
  end

  assign dividend = {d_q, 24'd0};

  always_comb begin
    for (int k = 0; k < UW; k++) begin
      if (k == 0) begin
        trial[k] = {dividend[UW+31:UW], dividend[UW-1]};
        dv_d[k].quo = '0;
        dv_d[k].low = {dividend[UW-2:0], 1'b0};
      end else begin
        trial[k] = {dv_q[k-1].rem, dv_q[k-1].low[UW-1]};
        dv_d[k].quo = dv_q[k-1].quo;
        dv_d[k].low = {dv_q[k-1].low[UW-2:0], 1'b0};
      end
      if (trial[k] >= {1'b0, pulse_length_i}) begin
        dv_d[k].rem = 32'(trial[k] - {1'b0, pulse_length_i});
        dv_d[k].quo = {dv_d[k].quo[UW-2:0], 1'b1};
      end else begin
        dv_d[k].rem = trial[k][31:0];
        dv_d[k].quo = {dv_d[k].quo[UW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < UW; k++) begin
      dv_q[k] <= dv_d[k];
    end
  end

  assign uu = 64'(dv_q[UW-1].quo) * 64'(dv_q[UW-1].quo);
  assign vv = uu >> 19;

  always_ff @(posedge clk_i) begin
    v_q  <= vv[34:0];
    zv_q <= (vv >= (64'd22 << 30));
    pl_q <= {29'd0, v_q[17:0]} * {18'd0, LOG2E_Q28};
    ph_q <= {29'd0, v_q[34:18]} * {17'd0, LOG2E_Q28};
    zw_q <= zv_q;
  end

  assign w = ((64'(ph_q) << 18) + 64'(pl_q)) >> 28;

  always_ff @(posedge clk_i) begin
    n_q  <= w[34:30];
    f_q  <= w[29:0];
    zf_q <= zw_q;
  end

  // The first Horner step multiplies by one, so the z product stage feeds it directly.
  always_comb begin
    z0           = mulq(Q_ONE - {1'b0, f_q}, {1'b0, LN2_Q30});
    ex_d[0].zero = zf_q;
    ex_d[0].n    = n_q;
    ex_d[0].z    = z0[29:0];
    ex_d[0].acc  = {1'b0, z0[29:0]};
    for (int i = 0; i < 12; i++) begin
      if (i > 0) begin
        ex_d[2*i]     = ex_q[2*i-1];
      end
      if (i > 0) begin
        ex_d[2*i].acc = mulq({1'b0, ex_q[2*i-1].z}, ex_q[2*i-1].acc);
      end
      ex_d[2*i+1]     = ex_q[2*i];
      ex_d[2*i+1].acc = Q_ONE + cdiv(ex_q[2*i].acc, EXP_RCP[i]);
    end
    shifted = 32'(ex_q[23].acc) >> (6'(ex_q[23].n) + 6'd1);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 24; i++) begin
      ex_q[i] <= ex_d[i];
    end
    if (ex_q[23].zero) begin
      env_q <= '0;
    end else begin
      env_q <= (shifted > 32'(Q_ONE)) ? Q_ONE : shifted[30:0];
    end
  end

  assign env_o = env_q;

endmodule
`default_nettype wire

/* rtl/core/gaussian_pulse_shaper.sv */
`default_nettype none
// Gaussian pulse shaper. Each start beat carries one sample time; the block returns one
// amplitude beat (Q1.15 cosine carrier, optionally under a gaussian envelope, zero outside
// the pulse) with done_o high for one cycle. Each result passes a pipelined divider in the
// envelope path, one quotient bit per stage (24 plus the clog2 of one more than the larger
// sigma constant), and 31 further stages around it. A new sample is taken every cycle and
// busy stays low; the receiver cannot stall, so results must be taken as they appear.
// Registers are written over the APB port and must only change while no samples are in
// flight.
module gaussian_pulse_shaper
  import gps_pkg::*;
#(
  parameter int unsigned SPAN_SIGMAS   = SPAN_SIGMAS_DEF,
  parameter int unsigned CENTER_SIGMAS = CENTER_SIGMAS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [3:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [31:0] sample_time_i,
  output logic signed      [15:0] amplitude_o,
  output logic                    in_window_o,
  output logic                    done_o
);

  localparam int unsigned MAXSC   = (SPAN_SIGMAS > CENTER_SIGMAS) ? SPAN_SIGMAS : CENTER_SIGMAS;
  localparam int unsigned UW      = 24 + $clog2(MAXSC + 1);
  localparam int unsigned ENV_LAT = UW + ENV_FIXED_STAGES;
  localparam int unsigned CAR_DLY = ENV_LAT - CAR_STAGES;
  localparam int unsigned LAT     = ENV_LAT + 2;

  typedef struct packed {
    logic vld;
    logic win;
  } ctl_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } car_t;

  logic [1:0]  mode_q;
  logic [31:0] step_q;
  logic [31:0] offset_q;
  logic [31:0] length_q;
  logic        wr_en;
  logic        accept;
  logic        win;
  ctl_t        ctl_q [ENV_LAT];
  car_t        cd_q [CAR_DLY];
  logic [30:0] car_mag;
  logic        car_neg;
  logic [30:0] env;
  ctl_t        pc_q;
  logic [30:0] pm_q;
  logic        pn_q;
  logic [31:0] scaled;
  logic [15:0] sat;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ZERO;
      step_q   <= '0;
      offset_q <= '0;
      length_q <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MODE:   mode_q   <= pwdata[1:0];
        REG_STEP:   step_q   <= pwdata;
        REG_OFFSET: offset_q <= pwdata;
        REG_LENGTH: length_q <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = {30'd0, mode_q};
      REG_STEP:   prdata = step_q;
      REG_OFFSET: prdata = offset_q;
      REG_LENGTH: prdata = length_q;
      default:    prdata = '0;
    endcase
  end

  assign win = (mode_q inside {MODE_RECT, MODE_GAUSS}) && (sample_time_i <= length_q) &&
               !((mode_q == MODE_GAUSS) && (length_q == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENV_LAT; i++) begin
        ctl_q[i] <= '0;
      end
      pc_q   <= '0;
      done_o <= 1'b0;
    end else begin
      ctl_q[0] <= '{vld: accept, win: accept && win};
      for (int i = 1; i < ENV_LAT; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
      pc_q   <= ctl_q[ENV_LAT-1];
      done_o <= pc_q.vld;
    end
  end

  gps_carrier u_carrier (
    .clk_i          (clk_i),
    .sample_time_i  (sample_time_i),
    .phase_step_i   (step_q),
    .phase_offset_i (offset_q),
    .mag_o          (car_mag),
    .neg_o          (car_neg)
  );

  gps_envelope #(
    .SPAN_SIGMAS   (SPAN_SIGMAS),
    .CENTER_SIGMAS (CENTER_SIGMAS)
  ) u_envelope (
    .clk_i          (clk_i),
    .sample_time_i  (sample_time_i),
    .pulse_length_i (length_q),
    .env_o          (env)
  );

  always_ff @(posedge clk_i) begin
    cd_q[0] <= '{neg: car_neg, mag: car_mag};
    for (int i = 1; i < CAR_DLY; i++) begin
      cd_q[i] <= cd_q[i-1];
    end
    pm_q <= mulq(cd_q[CAR_DLY-1].mag, (mode_q == MODE_GAUSS) ? env : Q_ONE);
    pn_q <= cd_q[CAR_DLY-1].neg;
  end

  generate
    if (AMP_FRAC_BITS < 30) begin : g_round
      localparam int unsigned SH = 30 - AMP_FRAC_BITS;
      assign scaled = (32'(pm_q) + (32'd1 << (SH - 1))) >> SH;
    end else if (AMP_FRAC_BITS == 30) begin : g_same
      assign scaled = 32'(pm_q);
    end else begin : g_up
      assign scaled = 32'(pm_q) << (AMP_FRAC_BITS - 30);
    end
  endgenerate

  assign sat = (scaled > 32'(AMP_MAX)) ? AMP_MAX : scaled[15:0];

  always_ff @(posedge clk_i) begin
    in_window_o <= pc_q.win;
    if (!pc_q.win) begin
      amplitude_o <= '0;
    end else begin
      amplitude_o <= pn_q ? -$signed(sat) : $signed(sat);
    end
  end

`ifndef SYNTHESIS
  a_out_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !in_window_o |-> amplitude_o == 16'sd0)
    else $error("amplitude nonzero outside the pulse window");

  a_no_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> amplitude_o != -16'sd32768)
    else $error("amplitude reached negative full scale");

  a_done_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result beat without a matching input beat");

  a_win_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_window_o |-> done_o)
    else $error("in_window set without a result beat");
`endif

endmodule
`default_nettype wire

/* bench/tb_gaussian_pulse_shaper.sv */
module tb_gaussian_pulse_shaper;
  import gps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SPAN = 8;
  localparam int unsigned CENTER = 4;
  localparam int unsigned LATENCY = 59;
  localparam longint unsigned CYCLE_LIMIT = 2000000;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic signed [15:0] amplitude;
    logic               in_window;
  } pulse_sample_t;

  class amplitude_scoreboard;
    pulse_sample_t pending[$];
    int unsigned   mismatches;
    int unsigned   checked;

    function void note_sample(pulse_sample_t s);
      pending.push_back(s);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_sample(pulse_sample_t got);
      pulse_sample_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected beat", got.amplitude, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.amplitude !== want.amplitude)
        report_mismatch("amplitude", got.amplitude, want.amplitude);
      if (got.in_window !== want.in_window)
        report_mismatch("in_window", got.in_window, want.in_window);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic start, busy;
  logic [31:0] sample_time_i;
  logic signed [15:0] amplitude_o;
  logic in_window_o, done_o;

  logic [1:0]  cur_mode;
  logic [31:0] cur_step, cur_offset, cur_length;
  longint unsigned cycles;
  int unsigned sent;
  amplitude_scoreboard board;

  gaussian_pulse_shaper dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic logic [63:0] cos_poly(logic [63:0] x2);
    logic [63:0] t;
    t = ONE_Q30 - x2 / 56;
    t = ONE_Q30 - ((x2 * t) >> 30) / 30;
    t = ONE_Q30 - ((x2 * t) >> 30) / 12;
    t = ONE_Q30 - ((x2 * t) >> 30) / 2;
    return t;
  endfunction

  function automatic logic [63:0] sin_poly(logic [63:0] x, logic [63:0] x2);
    logic [63:0] t;
    t = ONE_Q30 - x2 / 72;
    t = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic logic [63:0] gauss_env(logic [31:0] t, logic [31:0] len);
    logic [63:0] a, b, d, u, v, w, f, z, acc;
    logic [31:0] n;
    a = 64'(t) * SPAN;
    b = 64'(len) * CENTER;
    d = (a > b) ? a - b : b - a;
    u = (d << 24) / len;
    v = (u * u) >> 19;
    if (v >= (64'd22 << 30)) return 64'd0;
    w = (v * 64'(LOG2E_Q28)) >> 28;
    n = 32'(w >> 30);
    f = w & (ONE_Q30 - 1);
    z = ((ONE_Q30 - f) * 64'(LN2_Q30)) >> 30;
    acc = ONE_Q30;
    for (int k = 12; k >= 1; k--) acc = ONE_Q30 + ((z * acc) >> 30) / k;
    acc = acc >> (n + 1);
    return (acc > ONE_Q30) ? ONE_Q30 : acc;
  endfunction

  function automatic pulse_sample_t shape_sample(logic [31:0] t);
    pulse_sample_t s;
    logic [31:0] phase;
    logic [1:0]  quad;
    logic [63:0] r, x, mag;
    logic neg;
    s = '0;
    if ((cur_mode == MODE_RECT || cur_mode == MODE_GAUSS) && t <= cur_length &&
        !(cur_mode == MODE_GAUSS && cur_length == 0)) begin
      s.in_window = 1'b1;
      phase = t * cur_step + cur_offset;
      quad = phase[31:30];
      r = 64'(phase[29:0]);
      if (quad[0]) r = ONE_Q30 - r;
      neg = (quad == 2'd1 || quad == 2'd2);
      if (r <= (ONE_Q30 >> 1)) begin
        x = (r * 64'(HALF_PI_Q30)) >> 30;
        mag = cos_poly((x * x) >> 30);
      end else begin
        x = ((ONE_Q30 - r) * 64'(HALF_PI_Q30)) >> 30;
        mag = sin_poly(x, (x * x) >> 30);
      end
      if (mag > ONE_Q30) mag = ONE_Q30;
      if (cur_mode == MODE_GAUSS) mag = (mag * gauss_env(t, cur_length)) >> 30;
      mag = (mag + (64'd1 << 14)) >> 15;
      if (mag > 64'(AMP_MAX)) mag = 64'(AMP_MAX);
      s.amplitude = neg ? -16'(mag) : 16'(mag);
    end
    return s;
  endfunction

  task write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MODE:   cur_mode = value[1:0];
      REG_STEP:   cur_step = value;
      REG_OFFSET: cur_offset = value;
      default:    cur_length = value;
    endcase
  endtask

  task drain;
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task configure(logic [1:0] mode, logic [31:0] step, logic [31:0] offset,
                 logic [31:0] len);
    drain();
    write_reg(REG_MODE, {30'd0, mode});
    write_reg(REG_STEP, step);
    write_reg(REG_OFFSET, offset);
    write_reg(REG_LENGTH, len);
  endtask

  task send_sample(logic [31:0] t);
    start <= 1'b1;
    sample_time_i <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_sample(shape_sample(t));
    sent++;
    @(negedge clk_i);
  endtask

  task idle_gap(int unsigned n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_time(logic [31:0] len);
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return len + $urandom_range(0, 3);
      default: return (len == 0) ? 32'd0 : $urandom_range(0, len);
    endcase
  endfunction

  task random_phase(int unsigned count);
    logic [31:0] len;
    int unsigned burst;
    case ($urandom_range(0, 3))
      0: len = $urandom_range(0, 16);
      1: len = $urandom_range(17, 5000);
      2: len = $urandom();
      default: len = 32'hFFFF_FFFF;
    endcase
    configure(2'($urandom_range(0, 3) == 0 ? $urandom_range(2, 3) : $urandom_range(0, 1)),
              $urandom(), $urandom(), len);
    while (count > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && count > 0) begin
        send_sample(pick_time(len));
        burst--; count--;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
    end
    start <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_sample('{amplitude_o, in_window_o});
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gaussian_pulse_shaper test failed");
      $finish;
    end
  end

  initial begin
    board = new();
    cycles = 0; sent = 0;
    rst_ni = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; start = 1'b0; sample_time_i = '0;
    cur_mode = MODE_ZERO; cur_step = '0; cur_offset = '0; cur_length = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_sample(32'd0);
    send_sample(32'hFFFF_FFFF);
    idle_gap(1);
    configure(MODE_RECT, 32'd0, 32'd0, 32'd0);
    send_sample(32'd0);
    send_sample(32'd1);
    configure(MODE_GAUSS, 32'd0, 32'd0, 32'd0);
    send_sample(32'd0);
    send_sample(32'd5);
    configure(MODE_RECT, 32'h4000_0000, 32'h2000_0000, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) send_sample(32'(i));
    send_sample(32'hFFFF_FFFF);
    configure(MODE_GAUSS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd800);
    send_sample(32'd0);
    send_sample(32'd400);
    send_sample(32'd800);
    send_sample(32'd801);
    configure(2'd3, 32'd12345, 32'd0, 32'd100);
    send_sample(32'd10);
    send_sample(32'd0);
    idle_gap(1);
    for (int p = 0; p < 24; p++) random_phase(75);
    drain();
    $display("Sent %0d samples across many register settings; checked %0d beats.",
             sent, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("gaussian_pulse_shaper test passed");
    else
      $display("gaussian_pulse_shaper test failed");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/gps_pkg.sv
rtl/core/gps_carrier.sv
rtl/core/gps_envelope.sv
rtl/core/gaussian_pulse_shaper.sv
bench/tb_gaussian_pulse_shaper.sv
